/* rtl/mesh_tangent_accumulator_defines.svh */
// Assertion macros for the mesh tangent accumulator.
// No dependencies; included by files that carry concurrent checks.
`ifndef MESH_TANGENT_ACCUMULATOR_DEFINES_SVH
`define MESH_TANGENT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mta_pkg.sv */
// Shared types, widths and helpers for the mesh tangent accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mta_pkg;

  localparam int IDX_W         = 10;
  localparam int IDX_SPAN      = 1024;
  localparam int VTX_DEPTH_DEF = 1024;
  localparam int POS_W         = 32;
  localparam int UV_W          = 16;
  localparam int TAN_W         = 16;
  localparam int ACC_W         = 24;
  localparam int EPS_W         = 20;
  localparam int EPS_RESET     = 1;
  localparam int FUNC_W        = 2;
  localparam int IN_DATA_W     = 160;
  localparam int OUT_DATA_W    = 64;
  localparam int VTX_W         = 3 * POS_W + 2 * UV_W;
  localparam int ACCV_W        = 3 * ACC_W;
  localparam int EDGE_W        = POS_W + 1;
  localparam int DUV_W         = UV_W + 1;
  localparam int DET_W         = 2 * DUV_W + 1;
  localparam int MUL_A_W       = 33;
  localparam int MUL_B_W       = 31;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int MAG_W         = 52;
  localparam int SQ_W          = 30;
  localparam int SUM_W         = 62;
  localparam int ROOT_W        = 31;
  localparam int FRAC_SH       = 14;
  localparam int DIVD_W        = ROOT_W + FRAC_SH;
  localparam int Q_W           = 15;
  localparam int UNIT_Q14      = 16384;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TRI  = 2'd1,
    FUNC_EMIT = 2'd2
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_D,
    ST_DET_A, ST_DET_B, ST_DET_C, ST_DET_CHK,
    ST_DIR_A, ST_DIR_B, ST_DIR_C,
    ST_EM_RD, ST_EM_LD,
    ST_NRM_MAG, ST_NRM_SHIFT, ST_SQ_A, ST_SQ_B,
    ST_ROOT_GO, ST_ROOT_WAIT, ST_DIV_GO, ST_DIV_WAIT,
    ST_ACC_RD, ST_ACC_WR, ST_OUT
  } state_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [TAN_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/mta_store.sv */
// Vertex and tangent accumulator memories, one write and one registered read each.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_store #(
  parameter int DEPTH = mta_pkg::VTX_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          vtx_we,
  input  wire logic [$clog2(DEPTH)-1:0]      vtx_waddr,
  input  wire logic [mta_pkg::VTX_W-1:0]     vtx_wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      vtx_raddr,
  output logic      [mta_pkg::VTX_W-1:0]     vtx_rdata,
  input  wire logic                          acc_we,
  input  wire logic [$clog2(DEPTH)-1:0]      acc_waddr,
  input  wire logic [mta_pkg::ACCV_W-1:0]    acc_wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      acc_raddr,
  output logic      [mta_pkg::ACCV_W-1:0]    acc_rdata
);
  import mta_pkg::*;

  logic [VTX_W-1:0]  vtx_mem [DEPTH];
  logic [ACCV_W-1:0] acc_mem [DEPTH];
  logic [VTX_W-1:0]  vtx_rdata_r;
  logic [ACCV_W-1:0] acc_rdata_r;

  always_ff @(posedge clk) begin
    if (vtx_we) begin
      vtx_mem[vtx_waddr] <= vtx_wdata;
    end
    vtx_rdata_r <= vtx_mem[vtx_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata_r <= acc_mem[acc_raddr];
  end

  assign vtx_rdata = vtx_rdata_r;
  assign acc_rdata = acc_rdata_r;

endmodule

`default_nettype wire

/* rtl/mta_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_mul (
  input  wire logic                               clk,
  input  wire logic signed [mta_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [mta_pkg::MUL_B_W-1:0] b,
  output logic signed      [mta_pkg::PROD_W-1:0]  prod
);
  import mta_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* rtl/mta_root.sv */
// Bitwise integer square root, two radicand bits per cycle.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_root (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mta_pkg::SUM_W-1:0]    x,
  output logic                              done,
  output logic      [mta_pkg::ROOT_W-1:0]   root
);
  import mta_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [SUM_W-1:0] rem_r;
  logic [SUM_W-1:0] r_r;
  logic [SUM_W-1:0] bit_r;
  logic [SUM_W-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= x;
      r_r   <= '0;
      bit_r <= SUM_W'(1) << (SUM_W - 2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        r_r   <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

`default_nettype wire

/* rtl/mta_div.sv */
// Restoring divider for the Q1.14 scale step, one quotient bit per cycle.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mta_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [mta_pkg::ROOT_W-1:0]   divisor,
  output logic                              done,
  output logic      [mta_pkg::Q_W-1:0]      quot
);
  import mta_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [3:0]        cnt_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] dsh_r;
  logic [Q_W-1:0]    q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(Q_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {divisor, {FRAC_SH{1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_r <= {q_r[Q_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

/* rtl/mesh_tangent_accumulator.sv */
// Mesh tangent accumulator: per-vertex tangents from triangles, fixed point.
// A load is written on acceptance; a skipped triangle returns to idle at the determinant
// check, and a full triangle or an emit runs the normalizer's 31-step square root and
// three 15-step divides (none for a zero tangent), plus any stall on a waiting result.
// One request at a time; in_tready is high only while the sequencer is idle.
// Reset (rst_n, synchronous) clears control and sets the epsilon to 1; the vertex
// and accumulator memories are undefined until written and get no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_tangent_accumulator_defines.svh"

module mesh_tangent_accumulator #(
  parameter int VERTEX_DEPTH = mta_pkg::VTX_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // vertex_index, index_b, index_c, pos_x, pos_y, pos_z, tex_u, tex_v
  input  wire logic [mta_pkg::IN_DATA_W-1:0]    in_tdata,
  // func
  input  wire logic [mta_pkg::FUNC_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_vertex, tangent_x, tangent_y, tangent_z
  output logic      [mta_pkg::OUT_DATA_W-1:0]   out_tdata,
  // no_tangent
  output logic      [0:0]                       out_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mta_pkg::EPS_W-1:0]        cfg_data
);
  import mta_pkg::*;

  localparam int IDX_LIMIT = (VERTEX_DEPTH < IDX_SPAN) ? VERTEX_DEPTH : IDX_SPAN;
  localparam int ADDR_W    = $clog2(IDX_LIMIT);

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return int'(idx) < IDX_LIMIT;
  endfunction

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]  in_vi, in_ib, in_ic;
  logic [VTX_W-1:0]  in_vtx;
  logic              in_acc;
  logic              load_we;

  logic [EPS_W-1:0]  eps_r;
  logic [IDX_W-1:0]  ia_r, ib_r, ic_r;
  logic              emit_r;
  logic [1:0]        k_r;
  logic              notan_r;

  logic signed [POS_W-1:0]  pa_r [3];
  logic signed [UV_W-1:0]   ua_r, va_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [DUV_W-1:0]  du1_r, dv1_r, du2_r, dv2_r;
  logic signed [MAG_W-1:0]  acc_r;
  logic signed [DET_W-1:0]  det_r;
  logic                     det_neg_r;
  logic signed [MAG_W-1:0]  vec_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic [SUM_W-1:0]         sum_r;
  logic [ROOT_W-1:0]        n_r;
  logic signed [TAN_W-1:0]  t_r [3];

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_user_r;

  logic signed [POS_W-1:0]  rd_pos [3];
  logic signed [UV_W-1:0]   rd_u, rd_v;
  logic [VTX_W-1:0]         vtx_rdata;
  logic [ACCV_W-1:0]        acc_rdata;
  logic [ADDR_W-1:0]        vtx_raddr;
  logic [ADDR_W-1:0]        acc_raddr;
  logic                     acc_we;
  logic [ADDR_W-1:0]        acc_waddr;
  logic [ACCV_W-1:0]        acc_wdata;
  logic [IDX_W-1:0]         corner;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                root_start, root_done;
  logic [ROOT_W-1:0]   root_val;
  logic                div_start, div_done;
  logic [DIVD_W-1:0]   div_dividend;
  logic [Q_W-1:0]      div_q;

  logic [DET_W-1:0]         adet;
  logic                     det_skip;
  logic                     vec_zero;
  logic                     mag_big;
  logic signed [MAG_W-1:0]  dir_d;

  assign in_vi  = in_tdata[9:0];
  assign in_ib  = in_tdata[19:10];
  assign in_ic  = in_tdata[29:20];
  assign in_vtx = in_tdata[157:30];
  assign in_acc = in_tvalid && in_tready;
  assign load_we = in_acc && (func_t'(in_tuser) == FUNC_LOAD) && idx_ok(in_vi);

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_pos[0] = vtx_rdata[31:0];
  assign rd_pos[1] = vtx_rdata[63:32];
  assign rd_pos[2] = vtx_rdata[95:64];
  assign rd_u      = vtx_rdata[111:96];
  assign rd_v      = vtx_rdata[127:112];

  assign corner = (k_r == 2'd0) ? ia_r : ((k_r == 2'd1) ? ib_r : ic_r);

  always_comb begin
    case (state_r)
      ST_RD_B: vtx_raddr = ib_r[ADDR_W-1:0];
      ST_RD_C: vtx_raddr = ic_r[ADDR_W-1:0];
      default: vtx_raddr = ia_r[ADDR_W-1:0];
    endcase
  end

  assign acc_raddr = (state_r == ST_EM_RD) ? ia_r[ADDR_W-1:0] : corner[ADDR_W-1:0];
  assign acc_we    = load_we || (state_r == ST_ACC_WR);
  assign acc_waddr = load_we ? in_vi[ADDR_W-1:0] : corner[ADDR_W-1:0];
  assign acc_wdata = load_we ? '0 :
                     {sat_add(acc_rdata[71:48], t_r[2]),
                      sat_add(acc_rdata[47:24], t_r[1]),
                      sat_add(acc_rdata[23:0],  t_r[0])};

  always_comb begin
    case (state_r)
      ST_DET_A: begin
        mul_a = MUL_A_W'(du1_r);
        mul_b = MUL_B_W'(dv2_r);
      end
      ST_DET_B: begin
        mul_a = MUL_A_W'(du2_r);
        mul_b = MUL_B_W'(dv1_r);
      end
      ST_DIR_A: begin
        mul_a = e1_r[k_r];
        mul_b = MUL_B_W'(dv2_r);
      end
      ST_DIR_B: begin
        mul_a = e2_r[k_r];
        mul_b = MUL_B_W'(dv1_r);
      end
      ST_SQ_A: begin
        mul_a = MUL_A_W'(mag_r[k_r][SQ_W-1:0]);
        mul_b = MUL_B_W'(mag_r[k_r][SQ_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign adet     = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  assign det_skip = adet <= DET_W'(eps_r);
  assign vec_zero = (vec_r[0] == '0) && (vec_r[1] == '0) && (vec_r[2] == '0);
  assign mag_big  = (mag_r[0][MAG_W-1:SQ_W] != '0) || (mag_r[1][MAG_W-1:SQ_W] != '0) ||
                    (mag_r[2][MAG_W-1:SQ_W] != '0);
  assign dir_d    = acc_r - prod[MAG_W-1:0];

  assign root_start   = (state_r == ST_ROOT_GO);
  assign div_start    = (state_r == ST_DIV_GO);
  assign div_dividend = (DIVD_W'(mag_r[k_r][SQ_W-1:0]) << FRAC_SH) + DIVD_W'(n_r >> 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_tuser))
            FUNC_TRI: begin
              if (idx_ok(in_vi) && idx_ok(in_ib) && idx_ok(in_ic)) begin
                state_nxt = ST_RD_A;
              end
            end
            FUNC_EMIT: state_nxt = ST_EM_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_A:    state_nxt = ST_RD_B;
      ST_RD_B:    state_nxt = ST_RD_C;
      ST_RD_C:    state_nxt = ST_RD_D;
      ST_RD_D:    state_nxt = ST_DET_A;
      ST_DET_A:   state_nxt = ST_DET_B;
      ST_DET_B:   state_nxt = ST_DET_C;
      ST_DET_C:   state_nxt = ST_DET_CHK;
      ST_DET_CHK: state_nxt = det_skip ? ST_IDLE : ST_DIR_A;
      ST_DIR_A:   state_nxt = ST_DIR_B;
      ST_DIR_B:   state_nxt = ST_DIR_C;
      ST_DIR_C:   state_nxt = (k_r == 2'd2) ? ST_NRM_MAG : ST_DIR_A;
      ST_EM_RD:   state_nxt = ST_EM_LD;
      ST_EM_LD:   state_nxt = ST_NRM_MAG;
      ST_NRM_MAG: begin
        if (vec_zero) begin
          state_nxt = emit_r ? ST_OUT : ST_IDLE;
        end else begin
          state_nxt = ST_NRM_SHIFT;
        end
      end
      ST_NRM_SHIFT: state_nxt = mag_big ? ST_NRM_SHIFT : ST_SQ_A;
      ST_SQ_A:      state_nxt = ST_SQ_B;
      ST_SQ_B:      state_nxt = (k_r == 2'd2) ? ST_ROOT_GO : ST_SQ_A;
      ST_ROOT_GO:   state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: state_nxt = root_done ? ST_DIV_GO : ST_ROOT_WAIT;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (k_r != 2'd2) begin
            state_nxt = ST_DIV_GO;
          end else begin
            state_nxt = emit_r ? ST_OUT : ST_ACC_RD;
          end
        end
      end
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: state_nxt = (k_r == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= EPS_W'(EPS_RESET);
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        eps_r <= cfg_data;
      end
      case (state_r)
        ST_DIR_C, ST_SQ_B, ST_ACC_WR: k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        ST_DIV_WAIT: begin
          if (div_done) begin
            k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          end
        end
        ST_IDLE, ST_NRM_MAG: k_r <= '0;
        default: k_r <= k_r;
      endcase
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ia_r   <= in_vi;
      ib_r   <= in_ib;
      ic_r   <= in_ic;
      emit_r <= (func_t'(in_tuser) == FUNC_EMIT);
    end
    case (state_r)
      ST_RD_B: begin
        for (int j = 0; j < 3; j++) begin
          pa_r[j] <= rd_pos[j];
        end
        ua_r <= rd_u;
        va_r <= rd_v;
      end
      ST_RD_C: begin
        for (int j = 0; j < 3; j++) begin
          e1_r[j] <= EDGE_W'(rd_pos[j]) - EDGE_W'(pa_r[j]);
        end
        du1_r <= DUV_W'(rd_u) - DUV_W'(ua_r);
        dv1_r <= DUV_W'(rd_v) - DUV_W'(va_r);
      end
      ST_RD_D: begin
        for (int j = 0; j < 3; j++) begin
          e2_r[j] <= EDGE_W'(rd_pos[j]) - EDGE_W'(pa_r[j]);
        end
        du2_r <= DUV_W'(rd_u) - DUV_W'(ua_r);
        dv2_r <= DUV_W'(rd_v) - DUV_W'(va_r);
      end
      ST_DET_B, ST_DIR_B: acc_r <= prod[MAG_W-1:0];
      ST_DET_C:   det_r <= acc_r[DET_W-1:0] - prod[DET_W-1:0];
      ST_DET_CHK: det_neg_r <= det_r[DET_W-1];
      ST_DIR_C:   vec_r[k_r] <= det_neg_r ? -dir_d : dir_d;
      ST_EM_LD: begin
        for (int j = 0; j < 3; j++) begin
          vec_r[j] <= idx_ok(ia_r) ?
                      MAG_W'($signed(acc_rdata[ACC_W*j +: ACC_W])) : '0;
        end
      end
      ST_NRM_MAG: begin
        for (int j = 0; j < 3; j++) begin
          mag_r[j] <= vec_r[j][MAG_W-1] ? MAG_W'(-vec_r[j]) : MAG_W'(vec_r[j]);
        end
        notan_r <= vec_zero;
        sum_r   <= '0;
      end
      ST_NRM_SHIFT: begin
        if (mag_big) begin
          for (int j = 0; j < 3; j++) begin
            mag_r[j] <= mag_r[j] >> 1;
          end
        end
      end
      ST_SQ_B: sum_r <= sum_r + prod[SUM_W-1:0];
      ST_ROOT_WAIT: begin
        if (root_done) begin
          n_r <= root_val;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          t_r[k_r] <= vec_r[k_r][MAG_W-1] ? -TAN_W'(div_q) : TAN_W'(div_q);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_user_r <= notan_r;
          out_data_r <= notan_r ? {{(OUT_DATA_W-IDX_W){1'b0}}, ia_r} :
                        {{(OUT_DATA_W-IDX_W-3*TAN_W){1'b0}}, t_r[2], t_r[1], t_r[0], ia_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  mta_store #(
    .DEPTH(IDX_LIMIT)
  ) u_store (
    .clk      (clk),
    .vtx_we   (load_we),
    .vtx_waddr(in_vi[ADDR_W-1:0]),
    .vtx_wdata(in_vtx),
    .vtx_raddr(vtx_raddr),
    .vtx_rdata(vtx_rdata),
    .acc_we   (acc_we),
    .acc_waddr(acc_waddr),
    .acc_wdata(acc_wdata),
    .acc_raddr(acc_raddr),
    .acc_rdata(acc_rdata)
  );

  mta_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  mta_root u_root (
    .clk  (clk),
    .rst_n(rst_n),
    .start(root_start),
    .x    (sum_r),
    .done (root_done),
    .root (root_val)
  );

  mta_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (n_r),
    .done    (div_done),
    .quot    (div_q)
  );

  `MTA_ASSERT_NXT(a_out_only_from_seq, clk, rst_n, !out_valid_r && state_r != ST_OUT, !out_valid_r, "result raised outside output state")
  `MTA_ASSERT_NOW(a_quot_in_range, clk, rst_n, div_done, div_q <= Q_W'(UNIT_Q14), "tangent quotient above unit")
  `MTA_ASSERT_NOW(a_root_nonzero, clk, rst_n, root_done, root_val != '0, "zero norm for nonzero vector")
  `MTA_ASSERT_NOW(a_squares_fit, clk, rst_n, state_r == ST_SQ_A, !mag_big, "magnitude not scaled below square width")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Testbench for mesh_tangent_accumulator: vertex loads, triangles and tangent emits
// are checked against a fixed-point tangent predictor held in a scoreboard class.
// Depends on rtl/mta_pkg.sv and rtl/mesh_tangent_accumulator.sv.
`timescale 1ns / 1ps

module tb_top;
  import mta_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int MAX_CYCLES = 2000000;
  localparam int SETTLE = 300;

  typedef struct packed {
    logic [9:0]         vtx;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic               none;
  } tangent_t;

  typedef struct {
    logic [1:0]         func;
    logic [9:0]         ia;
    logic [9:0]         ib;
    logic [9:0]         ic;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] tu;
    logic signed [15:0] tv;
  } request_t;

  class tangent_scoreboard;
    logic [19:0] eps;
    longint pos_x[1024];
    longint pos_y[1024];
    longint pos_z[1024];
    longint tex_u[1024];
    longint tex_v[1024];
    longint acc_x[1024];
    longint acc_y[1024];
    longint acc_z[1024];
    tangent_t expected_tangents[$];
    int fails;

    function new();
      eps = EPS_RESET;
      fails = 0;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function bit unit_vec(input longint c[3], output longint o[3]);
      longint unsigned mag[3];
      longint unsigned m, total, n;
      int sh;
      m = 0;
      total = 0;
      sh = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i] < 0 ? -c[i] : c[i];
        if (mag[i] > m) m = mag[i];
        o[i] = 0;
      end
      if (m == 0) return 0;
      while ((m >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> sh;
        total += mag[i] * mag[i];
      end
      n = root(total);
      for (int i = 0; i < 3; i++) begin
        o[i] = longint'((mag[i] * UNIT_Q14 + n / 2) / n);
        if (c[i] < 0) o[i] = -o[i];
      end
      return 1;
    endfunction

    function longint clamp_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      return s;
    endfunction

    function void add_face(int a, int b, int c);
      longint e1[3], e2[3], d[3], t[3];
      longint du1, dv1, du2, dv2, det, adet;
      int corner[3];
      e1[0] = pos_x[b] - pos_x[a];
      e1[1] = pos_y[b] - pos_y[a];
      e1[2] = pos_z[b] - pos_z[a];
      e2[0] = pos_x[c] - pos_x[a];
      e2[1] = pos_y[c] - pos_y[a];
      e2[2] = pos_z[c] - pos_z[a];
      du1 = tex_u[b] - tex_u[a];
      dv1 = tex_v[b] - tex_v[a];
      du2 = tex_u[c] - tex_u[a];
      dv2 = tex_v[c] - tex_v[a];
      det = du1 * dv2 - du2 * dv1;
      adet = det < 0 ? -det : det;
      if (adet <= longint'(eps)) return;
      for (int k = 0; k < 3; k++) begin
        d[k] = dv2 * e1[k] - dv1 * e2[k];
        if (det < 0) d[k] = -d[k];
      end
      if (!unit_vec(d, t)) return;
      corner[0] = a;
      corner[1] = b;
      corner[2] = c;
      for (int k = 0; k < 3; k++) begin
        acc_x[corner[k]] = clamp_add(acc_x[corner[k]], t[0]);
        acc_y[corner[k]] = clamp_add(acc_y[corner[k]], t[1]);
        acc_z[corner[k]] = clamp_add(acc_z[corner[k]], t[2]);
      end
    endfunction

    function void note_request(request_t r);
      longint a[3], t[3];
      tangent_t e;
      case (r.func)
        FUNC_LOAD: begin
          pos_x[r.ia] = r.px;
          pos_y[r.ia] = r.py;
          pos_z[r.ia] = r.pz;
          tex_u[r.ia] = r.tu;
          tex_v[r.ia] = r.tv;
          acc_x[r.ia] = 0;
          acc_y[r.ia] = 0;
          acc_z[r.ia] = 0;
        end
        FUNC_TRI: add_face(r.ia, r.ib, r.ic);
        FUNC_EMIT: begin
          a[0] = acc_x[r.ia];
          a[1] = acc_y[r.ia];
          a[2] = acc_z[r.ia];
          e.none = !unit_vec(a, t);
          e.vtx = r.ia;
          e.tx = t[0];
          e.ty = t[1];
          e.tz = t[2];
          expected_tangents.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(tangent_t got);
      tangent_t e;
      if (expected_tangents.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        fails++;
        return;
      end
      e = expected_tangents.pop_front();
      if (got.vtx !== e.vtx) begin
        $display("%0t: out_vertex expected %0d actual %0d", $time, e.vtx, got.vtx);
        fails++;
      end
      if (got.tx !== e.tx) begin
        $display("%0t: tangent_x expected %0d actual %0d", $time, e.tx, got.tx);
        fails++;
      end
      if (got.ty !== e.ty) begin
        $display("%0t: tangent_y expected %0d actual %0d", $time, e.ty, got.ty);
        fails++;
      end
      if (got.tz !== e.tz) begin
        $display("%0t: tangent_z expected %0d actual %0d", $time, e.tz, got.tz);
        fails++;
      end
      if (got.none !== e.none) begin
        $display("%0t: no_tangent expected %0d actual %0d", $time, e.none, got.none);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [EPS_W-1:0] cfg_data = '0;

  tangent_scoreboard sb = new();
  int loaded[$];
  bit is_loaded[1024];
  int hold_req = 0;
  bit calm = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  mesh_tangent_accumulator u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result({out_tdata[9:0], out_tdata[25:10], out_tdata[41:26],
                       out_tdata[57:42], out_tuser[0]});
    end
  end

  initial begin : result_sink
    int n;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_tready = 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      n = pick_gap();
      out_tready = 1'b0;
      repeat (n) @(negedge clk);
      out_tready = 1'b1;
    end
  end

  task automatic send(request_t r);
    int n;
    n = pick_gap();
    repeat (n) @(negedge clk);
    in_tuser = r.func;
    in_tdata = {2'b00, r.tv, r.tu, r.pz, r.py, r.px, r.ic, r.ib, r.ia};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    if (r.func == FUNC_LOAD && !is_loaded[r.ia]) begin
      is_loaded[r.ia] = 1;
      loaded.push_back(r.ia);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    wait (sb.expected_tangents.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_eps(logic [19:0] v);
    drain();
    @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.eps = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load(int idx, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic signed [15:0] u, logic signed [15:0] v);
    request_t r;
    r = '{FUNC_LOAD, idx[9:0], 10'($urandom), 10'($urandom), x, y, z, u, v};
    send(r);
  endtask

  task automatic tri_req(int a, int b, int c);
    request_t r;
    r = '{FUNC_TRI, a[9:0], b[9:0], c[9:0], $urandom, $urandom, $urandom,
          16'($urandom), 16'($urandom)};
    send(r);
  endtask

  task automatic emit(int a);
    request_t r;
    r = '{FUNC_EMIT, a[9:0], 10'($urandom), 10'($urandom), $urandom, $urandom,
          $urandom, 16'($urandom), 16'($urandom)};
    send(r);
  endtask

  task automatic random_item();
    int r, a, b, c;
    request_t q;
    r = $urandom_range(0, 99);
    if (r < 30 || loaded.size() < 3) begin
      if ($urandom_range(0, 1))
        load($urandom_range(0, 1023), $urandom, $urandom, $urandom,
             16'($urandom), 16'($urandom));
      else
        load($urandom_range(0, 1023), $signed(20'($urandom)), $signed(20'($urandom)),
             $signed(20'($urandom)), $signed(12'($urandom)), $signed(12'($urandom)));
    end else if (r < 75) begin
      a = loaded[$urandom_range(0, loaded.size() - 1)];
      b = loaded[$urandom_range(0, loaded.size() - 1)];
      c = loaded[$urandom_range(0, loaded.size() - 1)];
      tri_req(a, b, c);
    end else if (r < 97) begin
      emit(loaded[$urandom_range(0, loaded.size() - 1)]);
    end else begin
      q = '{FUNC_NONE, 10'($urandom), 10'($urandom), 10'($urandom), $urandom, $urandom,
            $urandom, 16'($urandom), 16'($urandom)};
      send(q);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load(0, 0, 0, 0, 0, 0);
    load(1, 32'h0001_0000, 0, 0, 16'sd16384, 0);
    load(2, 0, 32'h0001_0000, 0, 0, 16'sd16384);
    load(1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000);
    load(512, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000, 16'sh7FFF);
    load(3, 32'h0002_0000, 0, 0, 16'sd16384, 16'sd16384);
    emit(0);
    tri_req(0, 1, 2);
    tri_req(0, 2, 1);
    tri_req(0, 0, 1);
    tri_req(1023, 512, 0);
    tri_req(0, 1, 3);
    emit(0);
    emit(1);
    emit(1023);
    send('{FUNC_NONE, 10'h3FF, 10'h3FF, 10'h3FF, -1, -1, -1, -1, -1});
    write_eps(20'hFFFFF);
    tri_req(0, 1, 2);
    emit(2);
    write_eps(0);
    tri_req(0, 1, 2);
    emit(2);

    calm = 1;
    load(10, 0, 0, 0, 0, 0);
    load(11, 32'h0001_0000, 0, 0, 16'sd16384, 0);
    load(12, 0, 32'h0001_0000, 0, 0, 16'sd16384);
    repeat (520) tri_req(10, 11, 12);
    calm = 0;
    emit(10);
    emit(11);

    hold_req = 600;
    repeat (6) emit(loaded[$urandom_range(0, loaded.size() - 1)]);
    write_eps(20'($urandom));
    repeat (300) random_item();
    drain();
    write_eps(20'($urandom_range(0, 4095)));
    repeat (300) random_item();
    write_eps(EPS_RESET);
    repeat (40) random_item();

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.fails == 0 && sb.expected_tangents.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
